// ===== hw/rtl/ps2mt_pkg.sv =====
`timescale 1ns / 1ps
package ps2mt_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int ACC_BITS_DEF = 32;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_SCREEN_WIDTH = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

	localparam logic [15:0] SCREEN_WIDTH_RESET = 16'd1920;
	localparam logic [15:0] SCREEN_HEIGHT_RESET = 16'd1080;

	localparam int SYNC_BIT = 3;
	localparam int X_SIGN_BIT = 4;
	localparam int Y_SIGN_BIT = 5;
	localparam int X_OVF_BIT = 6;
	localparam int Y_OVF_BIT = 7;

	typedef enum logic [1:0] {
		ACT_BYTE = 2'd0,
		ACT_INJECT = 2'd1,
		ACT_CONSUME = 2'd2
	} action_e;

	typedef enum logic [1:0] {
		BIDX_FLAGS = 2'd0,
		BIDX_X = 2'd1,
		BIDX_Y = 2'd2
	} byte_idx_t;

	typedef enum logic {
		KIND_POSITION = 1'b0,
		KIND_DELTA = 1'b1
	} kind_e;

	typedef struct packed {
		logic [15:0] screen_width;
		logic [15:0] screen_height;
	} cfg_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] data_byte;
		logic signed [15:0] inject_dx;
		logic signed [15:0] inject_dy;
		logic [2:0] inject_buttons;
	} in_item_t;

	typedef struct packed {
		logic kind;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [2:0] button_bits;
		logic signed [31:0] delta_x;
		logic signed [31:0] delta_y;
		logic present;
	} out_item_t;

endpackage

// ===== hw/rtl/ps2mt_ifs.sv =====
`timescale 1ns / 1ps
interface ps2mt_cmd_if;
	logic valid;
	logic ready;
	logic [1:0] action;
	logic [7:0] data_byte;
	logic signed [15:0] inject_dx;
	logic signed [15:0] inject_dy;
	logic [2:0] inject_buttons;

	modport source (output valid, action, data_byte, inject_dx, inject_dy, inject_buttons,
		input ready);
	modport sink (input valid, action, data_byte, inject_dx, inject_dy, inject_buttons,
		output ready);
endinterface

interface ps2mt_rsp_if;
	logic valid;
	logic ready;
	logic kind;
	logic [15:0] pos_x;
	logic [15:0] pos_y;
	logic [2:0] button_bits;
	logic signed [31:0] delta_x;
	logic signed [31:0] delta_y;
	logic present;

	modport source (output valid, kind, pos_x, pos_y, button_bits, delta_x, delta_y, present,
		input ready);
	modport sink (input valid, kind, pos_x, pos_y, button_bits, delta_x, delta_y, present,
		output ready);
endinterface

// ===== hw/rtl/ps2_mouse_packet_tracker_core.sv =====
`timescale 1ns / 1ps
// An accepted cmd item is held in item_s1; its result, if any, is registered in res_q for rsp.
// Throughput: one item per cycle unless a result stalls, set by the single add-and-clamp tracker update.
// The output register is refilled in the cycle it is taken, so a stall only costs the stalled cycles.
// Reset: asynchronous, active low; clears position, accumulators, buttons, present and packet
// phase, and sets the screen bounds to 1920 by 1080.
module ps2_mouse_packet_tracker_core
	import ps2mt_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int ACC_BITS = ACC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	ps2mt_cmd_if.sink          cmd,
	ps2mt_rsp_if.source        rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	cfg_t cfg;

	in_item_t item_s1;
	logic valid_s1;
	logic adv;

	byte_idx_t byte_idx_q;
	logic [7:0] flags_byte_q;
	logic [7:0] x_byte_q;
	logic [COORD_BITS-1:0] cur_x_q;
	logic [COORD_BITS-1:0] cur_y_q;
	logic [ACC_BITS-1:0] acc_dx_q;
	logic [ACC_BITS-1:0] acc_dy_q;
	logic [2:0] buttons_q;
	logic present_q;

	byte_idx_t nxt_byte_idx;
	logic [7:0] nxt_flags_byte;
	logic [7:0] nxt_x_byte;
	logic [COORD_BITS-1:0] nxt_x;
	logic [COORD_BITS-1:0] nxt_y;
	logic [ACC_BITS-1:0] nxt_acc_dx;
	logic [ACC_BITS-1:0] nxt_acc_dy;
	logic [2:0] nxt_buttons;
	logic nxt_present;
	logic emit;
	out_item_t res;

	out_item_t res_q;
	logic res_valid_q;

	ps2mt_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ps2mt_update #(
		.COORD_BITS (COORD_BITS),
		.ACC_BITS   (ACC_BITS)
	) u_update (
		.item           (item_s1),
		.cfg            (cfg),
		.byte_idx       (byte_idx_q),
		.flags_byte     (flags_byte_q),
		.x_byte         (x_byte_q),
		.cur_x          (cur_x_q),
		.cur_y          (cur_y_q),
		.acc_dx         (acc_dx_q),
		.acc_dy         (acc_dy_q),
		.cur_buttons    (buttons_q),
		.present_flag   (present_q),
		.nxt_byte_idx   (nxt_byte_idx),
		.nxt_flags_byte (nxt_flags_byte),
		.nxt_x_byte     (nxt_x_byte),
		.nxt_x          (nxt_x),
		.nxt_y          (nxt_y),
		.nxt_acc_dx     (nxt_acc_dx),
		.nxt_acc_dy     (nxt_acc_dy),
		.nxt_buttons    (nxt_buttons),
		.nxt_present    (nxt_present),
		.emit           (emit),
		.res            (res)
	);

	// The held item moves on unless it has a result and the output register stays full.
	assign adv = valid_s1 && (!emit || !res_valid_q || rsp.ready);
	assign cmd.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			item_s1.action <= cmd.action;
			item_s1.data_byte <= cmd.data_byte;
			item_s1.inject_dx <= cmd.inject_dx;
			item_s1.inject_dy <= cmd.inject_dy;
			item_s1.inject_buttons <= cmd.inject_buttons;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_idx_q <= BIDX_FLAGS;
			flags_byte_q <= '0;
			x_byte_q <= '0;
			cur_x_q <= '0;
			cur_y_q <= '0;
			acc_dx_q <= '0;
			acc_dy_q <= '0;
			buttons_q <= '0;
			present_q <= 1'b0;
		end else if (adv) begin
			byte_idx_q <= nxt_byte_idx;
			flags_byte_q <= nxt_flags_byte;
			x_byte_q <= nxt_x_byte;
			cur_x_q <= nxt_x;
			cur_y_q <= nxt_y;
			acc_dx_q <= nxt_acc_dx;
			acc_dy_q <= nxt_acc_dy;
			buttons_q <= nxt_buttons;
			present_q <= nxt_present;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && emit) begin
			res_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			res_q <= res;
		end
	end

	assign rsp.valid = res_valid_q;
	assign rsp.kind = res_q.kind;
	assign rsp.pos_x = res_q.pos_x;
	assign rsp.pos_y = res_q.pos_y;
	assign rsp.button_bits = res_q.button_bits;
	assign rsp.delta_x = res_q.delta_x;
	assign rsp.delta_y = res_q.delta_y;
	assign rsp.present = res_q.present;

	a_consume_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (item_s1.action == ACT_CONSUME) |=> (acc_dx_q == '0) && (acc_dy_q == '0))
		else $error("accumulators not cleared after a consume item");

	a_packet_end_emits: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (item_s1.action == ACT_BYTE) && (byte_idx_q == BIDX_Y)
		|=> res_valid_q && (res_q.kind == KIND_POSITION))
		else $error("completed packet gave no position event");

	a_stall_holds_item: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(item_s1))
		else $error("held item lost while the output register was full");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !rsp.ready |=> res_valid_q && $stable(res_q))
		else $error("pending result changed before it was taken");

endmodule

// ===== hw/rtl/ps2mt_cfg_regs.sv =====
`timescale 1ns / 1ps
module ps2mt_cfg_regs
	import ps2mt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t cfg_q;
	logic wr_en;
	logic [REG_IDX_W-1:0] reg_idx;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;
	assign reg_idx = paddr[PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width <= SCREEN_WIDTH_RESET;
			cfg_q.screen_height <= SCREEN_HEIGHT_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_SCREEN_WIDTH: cfg_q.screen_width <= pwdata[15:0];
				REG_SCREEN_HEIGHT: cfg_q.screen_height <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_SCREEN_WIDTH: prdata = {{(PDATA_W-16){1'b0}}, cfg_q.screen_width};
			REG_SCREEN_HEIGHT: prdata = {{(PDATA_W-16){1'b0}}, cfg_q.screen_height};
			default: prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/ps2mt_update.sv =====
`timescale 1ns / 1ps
module ps2mt_update
	import ps2mt_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int ACC_BITS = ACC_BITS_DEF
) (
	input  in_item_t              item,
	input  cfg_t                  cfg,
	input  byte_idx_t             byte_idx,
	input  logic [7:0]            flags_byte,
	input  logic [7:0]            x_byte,
	input  logic [COORD_BITS-1:0] cur_x,
	input  logic [COORD_BITS-1:0] cur_y,
	input  logic [ACC_BITS-1:0]   acc_dx,
	input  logic [ACC_BITS-1:0]   acc_dy,
	input  logic [2:0]            cur_buttons,
	input  logic                  present_flag,
	output byte_idx_t             nxt_byte_idx,
	output logic [7:0]            nxt_flags_byte,
	output logic [7:0]            nxt_x_byte,
	output logic [COORD_BITS-1:0] nxt_x,
	output logic [COORD_BITS-1:0] nxt_y,
	output logic [ACC_BITS-1:0]   nxt_acc_dx,
	output logic [ACC_BITS-1:0]   nxt_acc_dy,
	output logic [2:0]            nxt_buttons,
	output logic                  nxt_present,
	output logic                  emit,
	output out_item_t             res
);

	localparam int W = ((COORD_BITS > 16) ? COORD_BITS : 16) + 2;

	logic signed [8:0] pkt_dx9;
	logic signed [8:0] pkt_dy9;
	logic signed [15:0] mv_dx;
	logic signed [15:0] mv_dy_up;
	logic [15:0] hi_x;
	logic [15:0] hi_y;
	logic signed [W-1:0] sum_x;
	logic signed [W-1:0] sum_y;
	logic signed [W-1:0] hi_x_w;
	logic signed [W-1:0] hi_y_w;
	logic [COORD_BITS-1:0] clamp_x;
	logic [COORD_BITS-1:0] clamp_y;

	assign pkt_dx9 = flags_byte[X_OVF_BIT] ? 9'sd0 : $signed({flags_byte[X_SIGN_BIT], x_byte});
	assign pkt_dy9 = flags_byte[Y_OVF_BIT] ? 9'sd0 :
		$signed({flags_byte[Y_SIGN_BIT], item.data_byte});

	assign mv_dx = (item.action == ACT_INJECT) ? item.inject_dx : {{7{pkt_dx9[8]}}, pkt_dx9};
	assign mv_dy_up = (item.action == ACT_INJECT) ? item.inject_dy :
		{{7{pkt_dy9[8]}}, pkt_dy9};

	// A bound of zero behaves as a bound of one.
	assign hi_x = (cfg.screen_width == 16'd0) ? 16'd0 : cfg.screen_width - 16'd1;
	assign hi_y = (cfg.screen_height == 16'd0) ? 16'd0 : cfg.screen_height - 16'd1;
	assign hi_x_w = $signed({{(W-16){1'b0}}, hi_x});
	assign hi_y_w = $signed({{(W-16){1'b0}}, hi_y});

	assign sum_x = $signed({{(W-COORD_BITS){1'b0}}, cur_x}) + {{(W-16){mv_dx[15]}}, mv_dx};
	assign sum_y = $signed({{(W-COORD_BITS){1'b0}}, cur_y}) -
		{{(W-16){mv_dy_up[15]}}, mv_dy_up};

	always_comb begin
		priority if (sum_x < 0) begin
			clamp_x = '0;
		end else if (sum_x > hi_x_w) begin
			clamp_x = hi_x_w[COORD_BITS-1:0];
		end else begin
			clamp_x = sum_x[COORD_BITS-1:0];
		end
		priority if (sum_y < 0) begin
			clamp_y = '0;
		end else if (sum_y > hi_y_w) begin
			clamp_y = hi_y_w[COORD_BITS-1:0];
		end else begin
			clamp_y = sum_y[COORD_BITS-1:0];
		end
	end

	always_comb begin
		nxt_byte_idx = byte_idx;
		if (item.action == ACT_BYTE) begin
			unique case (byte_idx)
				BIDX_FLAGS: if (item.data_byte[SYNC_BIT]) nxt_byte_idx = BIDX_X;
				BIDX_X: nxt_byte_idx = BIDX_Y;
				BIDX_Y: nxt_byte_idx = BIDX_FLAGS;
				default: nxt_byte_idx = BIDX_FLAGS;
			endcase
		end
	end

	always_comb begin
		nxt_flags_byte = flags_byte;
		nxt_x_byte = x_byte;
		nxt_x = cur_x;
		nxt_y = cur_y;
		nxt_acc_dx = acc_dx;
		nxt_acc_dy = acc_dy;
		nxt_buttons = cur_buttons;
		nxt_present = present_flag;
		emit = 1'b0;
		unique case (item.action)
			ACT_BYTE: begin
				unique case (byte_idx)
					BIDX_FLAGS: if (item.data_byte[SYNC_BIT]) nxt_flags_byte = item.data_byte;
					BIDX_X: nxt_x_byte = item.data_byte;
					BIDX_Y: begin
						nxt_buttons = flags_byte[2:0];
						nxt_acc_dx = acc_dx + {{(ACC_BITS-9){pkt_dx9[8]}}, pkt_dx9};
						nxt_acc_dy = acc_dy - {{(ACC_BITS-9){pkt_dy9[8]}}, pkt_dy9};
						nxt_x = clamp_x;
						nxt_y = clamp_y;
						emit = 1'b1;
					end
					default: ;
				endcase
			end
			ACT_INJECT: begin
				nxt_x = clamp_x;
				nxt_y = clamp_y;
				nxt_buttons = item.inject_buttons;
				nxt_present = 1'b1;
				emit = 1'b1;
			end
			ACT_CONSUME: begin
				nxt_acc_dx = '0;
				nxt_acc_dy = '0;
				emit = 1'b1;
			end
			default: ;
		endcase
	end

	always_comb begin
		res.kind = (item.action == ACT_CONSUME) ? KIND_DELTA : KIND_POSITION;
		res.pos_x = 16'(nxt_x);
		res.pos_y = 16'(nxt_y);
		res.button_bits = nxt_buttons;
		res.delta_x = (item.action == ACT_CONSUME) ? 32'(acc_dx) : 32'sd0;
		res.delta_y = (item.action == ACT_CONSUME) ? 32'(acc_dy) : 32'sd0;
		res.present = nxt_present;
	end

endmodule
